>>> rtl/core/cdc_pkg.sv
// shared types, command codes and arithmetic helpers for the drive command controller
`default_nettype none
package cdc_pkg;

    localparam int CodeW   = 16;
    localparam int WordW   = 32;
    localparam int LevelW  = 11;
    localparam int DiscW   = 19;
    localparam int TrackW  = 7;

    // command codes
    localparam logic [CodeW-1:0] C_STOP_AUDIO   = 16'h0002;
    localparam logic [CodeW-1:0] C_PAUSE_AUDIO  = 16'h0003;
    localparam logic [CodeW-1:0] C_RESUME_AUDIO = 16'h0004;
    localparam logic [CodeW-1:0] C_READ_HOLD    = 16'h0008;
    localparam logic [CodeW-1:0] C_READ_GO      = 16'h0009;
    localparam logic [CodeW-1:0] C_STOP_ALL     = 16'h0010;
    localparam logic [CodeW-1:0] C_PLAY_CONT    = 16'h0011;
    localparam logic [CodeW-1:0] C_PLAY_ONCE    = 16'h0012;
    localparam logic [CodeW-1:0] C_PLAY_REPEAT  = 16'h0013;
    localparam logic [CodeW-1:0] C_READ_TO_END  = 16'h0017;
    localparam logic [CodeW-1:0] C_SEEK         = 16'h0018;
    localparam logic [CodeW-1:0] C_READ_COUNT   = 16'h0020;
    localparam logic [CodeW-1:0] C_READ_RANGE   = 16'h0021;
    localparam logic [CodeW-1:0] C_NOP          = 16'h0080;
    localparam logic [CodeW-1:0] C_STATUS       = 16'h0081;
    localparam logic [CodeW-1:0] C_VOLUME       = 16'h0085;
    localparam logic [CodeW-1:0] C_FADE         = 16'h0086;
    localparam logic [CodeW-1:0] C_READ_ACK_A   = 16'h0087;
    localparam logic [CodeW-1:0] C_READ_ACK_B   = 16'h0088;
    localparam logic [CodeW-1:0] C_CANCEL       = 16'h0089;
    localparam logic [CodeW-1:0] C_CHECK_READY  = 16'h008a;
    localparam logic [CodeW-1:0] C_HEADER       = 16'h008b;
    localparam logic [CodeW-1:0] C_HEADER_CHK   = 16'h008c;
    localparam logic [CodeW-1:0] C_ADVANCE      = 16'h008d;

    // configuration register indexes
    localparam logic CFG_DISC_LENGTH = 1'b0;
    localparam logic CFG_LAST_TRACK  = 1'b1;

    localparam logic [LevelW-1:0] UNITY_LEVEL   = 11'd1024;
    localparam logic [WordW-1:0]  LEAD_IN       = 32'd150;
    localparam logic [WordW-1:0]  ST_AUDIO_HELD = 32'h0000_0500;
    localparam logic [WordW-1:0]  ST_AUDIO_ON   = 32'h0000_0100;
    localparam logic [WordW-1:0]  ST_READ_HELD  = 32'h0000_0005;
    localparam logic [WordW-1:0]  ST_READ_ON    = 32'h0000_0001;
    localparam logic [7:0]        HDR_MODE      = 8'h01;

    // reciprocals for division by 75, 60 and 10
    localparam logic [31:0] RECIP_75 = 32'd3665038759;  // floor(2^38 / 75)
    localparam logic [26:0] RECIP_60 = 27'd71582788;    // floor(2^32 / 60)
    localparam logic [20:0] RECIP_10 = 21'd1677721;     // floor(2^24 / 10)

    typedef struct packed {
        logic              err;
        logic              unsup;
        logic              hdr;
        logic [WordW-1:0]  result;
        logic              active;
        logic [LevelW-1:0] gain;
    } t_side;

    function automatic logic [LevelW-1:0] clamp_level(input logic [15:0] v);
        clamp_level = (v > 16'(UNITY_LEVEL)) ? UNITY_LEVEL : v[LevelW-1:0];
    endfunction

    // two bcd digits of a value below 100
    function automatic logic [7:0] bcd_small(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  q;
        logic [6:0]  rem;
        p   = 15'(v) * 15'd205;
        q   = p[14:11];
        rem = v - 7'(q) * 7'd10;
        bcd_small = {q, rem[3:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/cdc_cmd.sv
// command decode, drive state registers and configuration registers
`default_nettype none
module cdc_cmd (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [15:0]               i_req_type,
    input  wire logic [15:0]               i_track_number,
    input  wire logic [31:0]               i_first_value,
    input  wire logic [31:0]               i_second_value,
    input  wire logic [31:0]               i_level_word,
    input  wire logic                      i_cfg_wr,
    input  wire logic                      i_cfg_addr,
    input  wire logic [18:0]               i_cfg_data,
    output cdc_pkg::t_side                 o_side,
    output logic [31:0]                    o_time
);

    logic [18:0] r_disc_length;
    logic [6:0]  r_last_track;

    logic [31:0] r_read_sector,  n_read_sector;
    logic [31:0] r_read_remaining, n_read_remaining;
    logic        r_read_held,    n_read_held;
    logic        r_audio_on,     n_audio_on;
    logic [6:0]  r_audio_track,  n_audio_track;
    logic [1:0]  r_audio_mode,   n_audio_mode;
    logic        r_audio_held,   n_audio_held;
    logic [10:0] r_cur_volume,   n_cur_volume;
    logic [10:0] r_master_level, n_master_level;
    logic [10:0] r_fade_goal,    n_fade_goal;
    logic [10:0] r_fade_inc,     n_fade_inc;

    logic [31:0] w_dl;
    logic [31:0] w_room;
    logic [31:0] w_count;
    logic [10:0] w_level;
    logic        w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc_length <= '0;
            r_last_track  <= 7'd1;
        end else if (i_cfg_wr) begin
            case (i_cfg_addr)
                cdc_pkg::CFG_DISC_LENGTH: r_disc_length <= i_cfg_data;
                cdc_pkg::CFG_LAST_TRACK:  r_last_track  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign w_dl    = {13'd0, r_disc_length};
    assign w_room  = w_dl - i_first_value;
    assign w_level = cdc_pkg::clamp_level({1'b0, i_level_word[14:0]});
    assign w_idle  = (r_read_remaining == '0) || r_read_held;
    assign o_time  = r_read_sector + cdc_pkg::LEAD_IN;

    always_comb begin
        n_read_sector    = r_read_sector;
        n_read_remaining = r_read_remaining;
        n_read_held      = r_read_held;
        n_audio_on       = r_audio_on;
        n_audio_track    = r_audio_track;
        n_audio_mode     = r_audio_mode;
        n_audio_held     = r_audio_held;
        n_cur_volume     = r_cur_volume;
        n_master_level   = r_master_level;
        n_fade_goal      = r_fade_goal;
        n_fade_inc       = r_fade_inc;
        o_side.err       = 1'b0;
        o_side.unsup     = 1'b0;
        o_side.hdr       = 1'b0;
        o_side.result    = '0;
        w_count          = i_second_value;

        case (i_req_type)
            cdc_pkg::C_STOP_AUDIO:   n_audio_on   = 1'b0;
            cdc_pkg::C_PAUSE_AUDIO:  n_audio_held = 1'b1;
            cdc_pkg::C_RESUME_AUDIO: n_audio_held = 1'b0;
            cdc_pkg::C_PLAY_CONT, cdc_pkg::C_PLAY_ONCE, cdc_pkg::C_PLAY_REPEAT: begin
                if (i_track_number < 16'd2 || i_track_number > {9'd0, r_last_track}) begin
                    o_side.err   = 1'b1;
                    o_side.unsup = 1'b1;
                end else begin
                    n_audio_on    = 1'b1;
                    n_audio_track = 7'(i_track_number - 16'd1);
                    n_audio_held  = 1'b0;
                    n_audio_mode  = i_req_type[1:0];
                end
            end
            cdc_pkg::C_READ_HOLD: n_read_held = 1'b1;
            cdc_pkg::C_READ_GO:   n_read_held = 1'b0;
            cdc_pkg::C_SEEK: begin
                n_read_sector    = i_first_value;
                n_read_remaining = '0;
                n_read_held      = 1'b1;
                n_audio_on       = 1'b0;
                o_side.err       = (i_first_value >= w_dl);
            end
            cdc_pkg::C_STOP_ALL: begin
                n_audio_on       = 1'b0;
                n_read_remaining = '0;
            end
            cdc_pkg::C_NOP: ;
            cdc_pkg::C_STATUS: begin
                if (r_audio_on) begin
                    o_side.result = r_audio_held ? cdc_pkg::ST_AUDIO_HELD
                                                 : cdc_pkg::ST_AUDIO_ON;
                end
                if (r_read_remaining != '0) begin
                    o_side.result = o_side.result | (r_read_held ? cdc_pkg::ST_READ_HELD
                                                                 : cdc_pkg::ST_READ_ON);
                end
            end
            cdc_pkg::C_READ_TO_END, cdc_pkg::C_READ_COUNT, cdc_pkg::C_READ_RANGE: begin
                n_read_sector = i_first_value;
                n_read_held   = 1'b0;
                n_audio_on    = 1'b0;
                if (i_req_type == cdc_pkg::C_READ_TO_END) begin
                    w_count = w_room;
                end else if (i_req_type == cdc_pkg::C_READ_RANGE) begin
                    w_count = i_second_value - i_first_value;
                end
                if (i_first_value >= w_dl || w_count > w_room) begin
                    n_read_remaining = '0;
                    o_side.err       = 1'b1;
                end else begin
                    n_read_remaining = w_count;
                end
            end
            cdc_pkg::C_VOLUME: begin
                if (i_level_word[15]) begin
                    n_master_level = w_level;
                end else begin
                    n_cur_volume = w_level;
                    n_fade_goal  = w_level;
                    n_fade_inc   = '0;
                end
            end
            cdc_pkg::C_FADE: begin
                n_fade_goal = cdc_pkg::clamp_level(i_level_word[31:16]);
                n_fade_inc  = cdc_pkg::clamp_level(i_level_word[15:0]);
            end
            cdc_pkg::C_READ_ACK_A, cdc_pkg::C_READ_ACK_B: n_read_held = 1'b0;
            cdc_pkg::C_CANCEL:      n_read_remaining = '0;
            cdc_pkg::C_CHECK_READY: o_side.err = w_idle;
            cdc_pkg::C_HEADER: begin
                o_side.err = w_idle;
                o_side.hdr = !w_idle;
            end
            cdc_pkg::C_HEADER_CHK: begin
                o_side.err = w_idle || (r_read_sector >= w_dl);
                o_side.hdr = !o_side.err;
            end
            cdc_pkg::C_ADVANCE: begin
                if (r_read_remaining != '0) begin
                    n_read_sector    = r_read_sector + 32'd1;
                    n_read_remaining = r_read_remaining - 32'd1;
                end
            end
            default: begin
                o_side.err   = 1'b1;
                o_side.unsup = 1'b1;
            end
        endcase

        o_side.active = n_audio_on && !n_audio_held;
        o_side.gain   = (n_cur_volume < n_master_level) ? n_cur_volume : n_master_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_sector    <= '0;
            r_read_remaining <= '0;
            r_read_held      <= 1'b0;
            r_audio_on       <= 1'b0;
            r_audio_track    <= '0;
            r_audio_mode     <= '0;
            r_audio_held     <= 1'b0;
            r_cur_volume     <= cdc_pkg::UNITY_LEVEL;
            r_master_level   <= cdc_pkg::UNITY_LEVEL;
            r_fade_goal      <= cdc_pkg::UNITY_LEVEL;
            r_fade_inc       <= '0;
        end else if (i_accept) begin
            r_read_sector    <= n_read_sector;
            r_read_remaining <= n_read_remaining;
            r_read_held      <= n_read_held;
            r_audio_on       <= n_audio_on;
            r_audio_track    <= n_audio_track;
            r_audio_mode     <= n_audio_mode;
            r_audio_held     <= n_audio_held;
            r_cur_volume     <= n_cur_volume;
            r_master_level   <= n_master_level;
            r_fade_goal      <= n_fade_goal;
            r_fade_inc       <= n_fade_inc;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cdc_pipe.sv
// result pipeline: minute-second-frame header conversion and output register
`default_nettype none
module cdc_pipe (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire cdc_pkg::t_side  i_side,
    input  wire logic [31:0]     i_time,
    input  wire logic            i_stall,
    output logic                 o_adv,
    output logic                 o_valid,
    output logic                 o_error_flag,
    output logic                 o_unsupported_flag,
    output logic [31:0]          o_result_value,
    output logic                 o_audio_active,
    output logic [10:0]          o_playback_gain
);

    logic [7:1] r_v;
    cdc_pkg::t_side r_side1, r_side2, r_side3, r_side4, r_side5, r_side6, r_side7;

    logic [31:0] r_t1, r_t2;
    logic [25:0] r_qa;
    logic [25:0] r_q75_3, r_q75_4, n_q75;
    logic [6:0]  r_f3, r_f4, r_f5, r_f6, r_f7, n_f;
    logic [19:0] r_qb;
    logic [19:0] r_m5, r_m6, n_m;
    logic [5:0]  r_s5, r_s6, r_s7, n_s;
    logic [16:0] r_qc;
    logic [3:0]  r_mt, n_mt;
    logic [3:0]  r_md, n_md;

    logic [63:0] w_p1;
    logic [52:0] w_p2;
    logic [40:0] w_p3;
    logic [7:0]  w_r1;
    logic [6:0]  w_r2;
    logic [4:0]  w_r3;
    logic [16:0] w_qc;

    assign o_adv = !o_valid || !i_stall;

    assign w_p1 = 64'(r_t1) * 64'(cdc_pkg::RECIP_75);
    assign w_p2 = 53'(r_q75_3) * 53'(cdc_pkg::RECIP_60);
    assign w_p3 = 41'(r_m5) * 41'(cdc_pkg::RECIP_10);

    // quotient estimates are exact or one low; one compare and subtract fixes them
    always_comb begin
        w_r1 = 8'(r_t2 - 32'(r_qa) * 32'd75);
        if (w_r1 >= 8'd75) begin
            n_q75 = r_qa + 26'd1;
            n_f   = 7'(w_r1 - 8'd75);
        end else begin
            n_q75 = r_qa;
            n_f   = w_r1[6:0];
        end

        w_r2 = 7'(r_q75_4 - 26'(r_qb) * 26'd60);
        if (w_r2 >= 7'd60) begin
            n_m = r_qb + 20'd1;
            n_s = 6'(w_r2 - 7'd60);
        end else begin
            n_m = r_qb;
            n_s = w_r2[5:0];
        end

        w_r3 = 5'(r_m6 - 20'(r_qc) * 20'd10);
        if (w_r3 >= 5'd10) begin
            w_qc = r_qc + 17'd1;
            n_md = 4'(w_r3 - 5'd10);
        end else begin
            w_qc = r_qc;
            n_md = w_r3[3:0];
        end
        n_mt = w_qc[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (o_adv) begin
            r_v     <= {r_v[6:1], i_valid};
            o_valid <= r_v[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_side1 <= i_side;
            r_t1    <= i_time;
            r_qa    <= w_p1[63:38];
            r_t2    <= r_t1;
            r_side2 <= r_side1;
            r_q75_3 <= n_q75;
            r_f3    <= n_f;
            r_side3 <= r_side2;
            r_qb    <= w_p2[51:32];
            r_q75_4 <= r_q75_3;
            r_f4    <= r_f3;
            r_side4 <= r_side3;
            r_m5    <= n_m;
            r_s5    <= n_s;
            r_f5    <= r_f4;
            r_side5 <= r_side4;
            r_qc    <= w_p3[40:24];
            r_m6    <= r_m5;
            r_s6    <= r_s5;
            r_f6    <= r_f5;
            r_side6 <= r_side5;
            r_mt    <= n_mt;
            r_md    <= n_md;
            r_s7    <= r_s6;
            r_f7    <= r_f6;
            r_side7 <= r_side6;

            o_error_flag       <= r_side7.err;
            o_unsupported_flag <= r_side7.unsup;
            o_audio_active     <= r_side7.active;
            o_playback_gain    <= r_side7.gain;
            o_result_value     <= r_side7.hdr
                ? {r_mt, r_md, cdc_pkg::bcd_small({1'b0, r_s7}),
                   cdc_pkg::bcd_small(r_f7), cdc_pkg::HDR_MODE}
                : r_side7.result;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/cd_drive_command_controller.sv
// top level of the drive command controller
//
//  channel  | direction | handshake               | payload
//  command  | in        | i_valid / o_stall       | req_type, track_number, first/second_value,
//           |           |                         | level_word
//  result   | out       | o_valid / i_stall       | error/unsupported flags, result_value,
//           |           |                         | audio_active, playback_gain
//  config   | in        | i_cfg_wr                | i_cfg_addr, i_cfg_data
//
// one command transfer per cycle while the result channel is not stalled; each result passes
// through the staged reciprocal divisions of the sector header conversion
// drive state updates at the command transfer edge
// a stalled valid result freezes the whole pipeline and raises o_stall
// synchronous active-low reset restores the power-up drive and volume state
`default_nettype none
module cd_drive_command_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_req_type,
    input  wire logic [15:0] i_track_number,
    input  wire logic [31:0] i_first_value,
    input  wire logic [31:0] i_second_value,
    input  wire logic [31:0] i_level_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_error_flag,
    output logic             o_unsupported_flag,
    output logic [31:0]      o_result_value,
    output logic             o_audio_active,
    output logic [10:0]      o_playback_gain,
    input  wire logic        i_cfg_wr,
    input  wire logic        i_cfg_addr,
    input  wire logic [18:0] i_cfg_data
);

    logic           w_adv;
    logic           w_accept;
    cdc_pkg::t_side w_side;
    logic [31:0]    w_time;

    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;

    cdc_cmd u_cmd (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_req_type     (i_req_type),
        .i_track_number (i_track_number),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_level_word   (i_level_word),
        .i_cfg_wr       (i_cfg_wr),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_side         (w_side),
        .o_time         (w_time)
    );

    cdc_pipe u_pipe (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (w_accept),
        .i_side             (w_side),
        .i_time             (w_time),
        .i_stall            (i_stall),
        .o_adv              (w_adv),
        .o_valid            (o_valid),
        .o_error_flag       (o_error_flag),
        .o_unsupported_flag (o_unsupported_flag),
        .o_result_value     (o_result_value),
        .o_audio_active     (o_audio_active),
        .o_playback_gain    (o_playback_gain)
    );

endmodule
`default_nettype wire

>>> test/cd_drive_command_controller_test.sv
// self-checking testbench for the drive command controller, with its own drive state predictor
`timescale 1ns / 1ps
`default_nettype none
module cd_drive_command_controller_test;

    localparam logic [15:0] BOGUS_LOW   = 16'h0000;
    localparam logic [15:0] BOGUS_HIGH  = 16'hffff;
    localparam logic [15:0] BOGUS_ALIAS = 16'h0181;

    typedef struct packed {
        logic [15:0] code;
        logic [15:0] track;
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] level;
    } t_drive_cmd;

    typedef struct packed {
        logic        err;
        logic        unsup;
        logic [31:0] result;
        logic        active;
        logic [10:0] gain;
    } t_drive_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_req_type = '0;
    logic [15:0] i_track_number = '0;
    logic [31:0] i_first_value = '0;
    logic [31:0] i_second_value = '0;
    logic [31:0] i_level_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_error_flag;
    logic        o_unsupported_flag;
    logic [31:0] o_result_value;
    logic        o_audio_active;
    logic [10:0] o_playback_gain;
    logic        i_cfg_wr = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [18:0] i_cfg_data = '0;

    cd_drive_command_controller dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_req_type         (i_req_type),
        .i_track_number     (i_track_number),
        .i_first_value      (i_first_value),
        .i_second_value     (i_second_value),
        .i_level_word       (i_level_word),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_error_flag       (o_error_flag),
        .o_unsupported_flag (o_unsupported_flag),
        .o_result_value     (o_result_value),
        .o_audio_active     (o_audio_active),
        .o_playback_gain    (o_playback_gain),
        .i_cfg_wr           (i_cfg_wr),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data)
    );

    // predicted drive state
    logic [31:0] disc_len = '0;
    logic [6:0]  last_trk = 7'd1;
    logic [31:0] rd_sector = '0;
    logic [31:0] rd_left = '0;
    logic        rd_held = 1'b0;
    logic        au_on = 1'b0;
    logic [6:0]  au_track = '0;
    logic [1:0]  au_mode = '0;
    logic        au_held = 1'b0;
    logic [10:0] vol_now = 11'd1024;
    logic [10:0] vol_master = 11'd1024;
    logic [10:0] fade_goal = 11'd1024;
    logic [10:0] fade_inc = '0;

    t_drive_reply pending_replies[$];
    int mismatch_count = 0;
    int send_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [10:0] to_unity(input logic [15:0] v);
        return (v > 16'd1024) ? 11'd1024 : v[10:0];
    endfunction

    function automatic logic [31:0] bcd_digits(input logic [31:0] v);
        return (v / 32'd10) * 32'd16 + v % 32'd10;
    endfunction

    function automatic logic [31:0] header_bcd(input logic [31:0] lba);
        logic [31:0] t;
        t = lba + cdc_pkg::LEAD_IN;
        return (bcd_digits(t / 32'd4500) << 24) | (bcd_digits((t / 32'd75) % 32'd60) << 16) |
               (bcd_digits(t % 32'd75) << 8) | 32'd1;
    endfunction

    function automatic t_drive_reply predict_drive_reply(input t_drive_cmd c);
        t_drive_reply r;
        logic [31:0]  span;
        logic [10:0]  lvl;
        r = '0;
        case (c.code)
            cdc_pkg::C_STOP_AUDIO:   au_on = 1'b0;
            cdc_pkg::C_PAUSE_AUDIO:  au_held = 1'b1;
            cdc_pkg::C_RESUME_AUDIO: au_held = 1'b0;
            cdc_pkg::C_PLAY_CONT, cdc_pkg::C_PLAY_ONCE, cdc_pkg::C_PLAY_REPEAT: begin
                if (c.track < 16'd2 || c.track > {9'd0, last_trk}) begin
                    r.err = 1'b1;
                    r.unsup = 1'b1;
                end else begin
                    au_on = 1'b1;
                    au_track = 7'(c.track - 16'd1);
                    au_held = 1'b0;
                    au_mode = c.code[1:0];
                end
            end
            cdc_pkg::C_READ_HOLD: rd_held = 1'b1;
            cdc_pkg::C_READ_GO:   rd_held = 1'b0;
            cdc_pkg::C_SEEK: begin
                rd_sector = c.first;
                rd_left = '0;
                rd_held = 1'b1;
                au_on = 1'b0;
                if (c.first >= disc_len) r.err = 1'b1;
            end
            cdc_pkg::C_STOP_ALL: begin
                au_on = 1'b0;
                rd_left = '0;
            end
            cdc_pkg::C_NOP: ;
            cdc_pkg::C_STATUS: begin
                r.result = au_on ? (au_held ? cdc_pkg::ST_AUDIO_HELD : cdc_pkg::ST_AUDIO_ON)
                                 : '0;
                if (rd_left != 0)
                    r.result |= rd_held ? cdc_pkg::ST_READ_HELD : cdc_pkg::ST_READ_ON;
            end
            cdc_pkg::C_READ_TO_END, cdc_pkg::C_READ_COUNT, cdc_pkg::C_READ_RANGE: begin
                rd_sector = c.first;
                rd_held = 1'b0;
                au_on = 1'b0;
                span = (c.code == cdc_pkg::C_READ_TO_END) ? disc_len - c.first : c.second;
                if (c.code == cdc_pkg::C_READ_RANGE) span = span - c.first;
                if (c.first >= disc_len || span > disc_len - c.first) begin
                    span = '0;
                    r.err = 1'b1;
                end
                rd_left = span;
            end
            cdc_pkg::C_VOLUME: begin
                lvl = to_unity({1'b0, c.level[14:0]});
                if (c.level[15]) begin
                    vol_master = lvl;
                end else begin
                    vol_now = lvl;
                    fade_goal = lvl;
                    fade_inc = '0;
                end
            end
            cdc_pkg::C_FADE: begin
                fade_goal = to_unity(c.level[31:16]);
                fade_inc = to_unity(c.level[15:0]);
            end
            cdc_pkg::C_READ_ACK_A, cdc_pkg::C_READ_ACK_B: rd_held = 1'b0;
            cdc_pkg::C_CANCEL: rd_left = '0;
            cdc_pkg::C_CHECK_READY: if (rd_left == 0 || rd_held) r.err = 1'b1;
            cdc_pkg::C_HEADER: begin
                if (rd_left == 0 || rd_held) r.err = 1'b1;
                else r.result = header_bcd(rd_sector);
            end
            cdc_pkg::C_HEADER_CHK: begin
                if (rd_left == 0 || rd_held || rd_sector >= disc_len) r.err = 1'b1;
                else r.result = header_bcd(rd_sector);
            end
            cdc_pkg::C_ADVANCE: begin
                if (rd_left != 0) begin
                    rd_sector = rd_sector + 32'd1;
                    rd_left = rd_left - 32'd1;
                end
            end
            default: begin
                r.err = 1'b1;
                r.unsup = 1'b1;
            end
        endcase
        r.active = au_on && !au_held;
        r.gain = (vol_now < vol_master) ? vol_now : vol_master;
        return r;
    endfunction

    // receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_drive_reply want;
        t_drive_reply got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_error_flag, o_unsupported_flag, o_result_value, o_audio_active,
                   o_playback_gain};
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("extra transfer: err %0b unsup %0b res %h act %0b gain %0d",
                             got.err, got.unsup, got.result, got.active, got.gain);
            end else begin
                want = pending_replies.pop_front();
                if (want.err !== got.err || want.unsup !== got.unsup ||
                        want.result !== got.result || want.active !== got.active ||
                        want.gain !== got.gain) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("exp/act: err %0b/%0b unsup %0b/%0b res %h/%h",
                                 want.err, got.err, want.unsup, got.unsup,
                                 want.result, got.result,
                                 " act %0b/%0b gain %0d/%0d",
                                 want.active, got.active, want.gain, got.gain);
                end
            end
        end
    end

    task automatic issue_command(input t_drive_cmd c);
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= c.code;
        i_track_number <= c.track;
        i_first_value  <= c.first;
        i_second_value <= c.second;
        i_level_word   <= c.level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_replies.push_back(predict_drive_reply(c));
    endtask

    task automatic issue(input logic [15:0] code, input logic [15:0] track,
                         input logic [31:0] first, input logic [31:0] second,
                         input logic [31:0] level);
        issue_command({code, track, first, second, level});
    endtask

    task automatic wait_for_replies();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_drive_register(input logic addr, input logic [18:0] value);
        i_cfg_wr   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (addr == cdc_pkg::CFG_DISC_LENGTH) disc_len = {13'd0, value};
        else last_trk = value[6:0];
        i_cfg_wr <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_disc(input logic [18:0] sectors, input logic [6:0] tracks);
        wait_for_replies();
        write_drive_register(cdc_pkg::CFG_DISC_LENGTH, sectors);
        write_drive_register(cdc_pkg::CFG_LAST_TRACK, {12'd0, tracks});
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 31))
            0:          return cdc_pkg::C_STOP_AUDIO;
            1:          return cdc_pkg::C_PAUSE_AUDIO;
            2:          return cdc_pkg::C_RESUME_AUDIO;
            3:          return cdc_pkg::C_READ_HOLD;
            4:          return cdc_pkg::C_READ_GO;
            5:          return cdc_pkg::C_STOP_ALL;
            6:          return cdc_pkg::C_PLAY_CONT;
            7:          return cdc_pkg::C_PLAY_ONCE;
            8:          return cdc_pkg::C_PLAY_REPEAT;
            9:          return cdc_pkg::C_READ_TO_END;
            10:         return cdc_pkg::C_SEEK;
            11, 12:     return cdc_pkg::C_READ_COUNT;
            13:         return cdc_pkg::C_READ_RANGE;
            14:         return cdc_pkg::C_NOP;
            15, 16:     return cdc_pkg::C_STATUS;
            17:         return cdc_pkg::C_VOLUME;
            18:         return cdc_pkg::C_FADE;
            19:         return cdc_pkg::C_READ_ACK_A;
            20:         return cdc_pkg::C_READ_ACK_B;
            21:         return cdc_pkg::C_CANCEL;
            22:         return cdc_pkg::C_CHECK_READY;
            23, 24:     return cdc_pkg::C_HEADER;
            25, 26:     return cdc_pkg::C_HEADER_CHK;
            27, 28, 29: return cdc_pkg::C_ADVANCE;
            default:    return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_drive_cmd random_command();
        t_drive_cmd c;
        c.code = pick_code();
        if ($urandom_range(0, 9) == 0) c.track = 16'($urandom);
        else c.track = 16'($urandom_range(0, last_trk + 2));
        case ($urandom_range(0, 5))
            0:       c.first = $urandom;
            1:       c.first = disc_len - $urandom_range(0, 3);
            default: c.first = $urandom_range(0, disc_len + 2);
        endcase
        case ($urandom_range(0, 5))
            0:       c.second = $urandom;
            1:       c.second = disc_len - c.first + $urandom_range(0, 1);
            2:       c.second = c.first + $urandom_range(0, 40);
            default: c.second = $urandom_range(0, 40);
        endcase
        case ($urandom_range(0, 3))
            0:       c.level = $urandom;
            1:       c.level = {16'($urandom), 1'($urandom), 15'($urandom_range(0, 1100))};
            default: c.level = {16'($urandom_range(0, 1100)), 16'($urandom_range(0, 1100))};
        endcase
        return c;
    endfunction

    task automatic test_power_up_state();
        issue(cdc_pkg::C_STATUS, '0, '0, '0, '0);
        issue(cdc_pkg::C_HEADER, '0, '0, '0, '0);
        issue(cdc_pkg::C_ADVANCE, '0, '0, '0, '0);
        issue(cdc_pkg::C_PLAY_CONT, 16'd2, '0, '0, '0);
        issue(cdc_pkg::C_SEEK, '0, '0, '0, '0);
        issue(BOGUS_HIGH, 16'hffff, '1, '1, '1);
        issue(BOGUS_ALIAS, '0, '0, '0, '0);
        issue(BOGUS_LOW, '0, '0, '0, '0);
    endtask

    task automatic test_audio_play();
        issue(cdc_pkg::C_PLAY_CONT, 16'd2, '0, '0, '0);
        issue(cdc_pkg::C_PAUSE_AUDIO, '0, '0, '0, '0);
        issue(cdc_pkg::C_STATUS, '0, '0, '0, '0);
        issue(cdc_pkg::C_PLAY_ONCE, 16'd99, '0, '0, '0);
        issue(cdc_pkg::C_PLAY_REPEAT, 16'd100, '0, '0, '0);
        issue(cdc_pkg::C_PLAY_ONCE, 16'd1, '0, '0, '0);
    endtask

    task automatic test_sector_reads();
        // minute count above 99 near the end of a full-size disc
        issue(cdc_pkg::C_READ_COUNT, '0, 32'd524200, 32'd30, '0);
        issue(cdc_pkg::C_HEADER, '0, '0, '0, '0);
        issue(cdc_pkg::C_READ_HOLD, '0, '0, '0, '0);
        issue(cdc_pkg::C_HEADER_CHK, '0, '0, '0, '0);
        issue(cdc_pkg::C_READ_RANGE, '0, 32'd10, 32'd5, '0);
        issue(cdc_pkg::C_SEEK, '0, 32'd524287, '0, '0);
    endtask

    task automatic test_shrunk_disc();
        issue(cdc_pkg::C_READ_RANGE, '0, 32'd100, 32'd150, '0);
        set_disc(19'd100, 7'd99);
        issue(cdc_pkg::C_HEADER_CHK, '0, '0, '0, '0);
    endtask

    task automatic test_levels();
        issue(cdc_pkg::C_VOLUME, '0, '0, '0, 32'h0000_7fff);
        issue(cdc_pkg::C_VOLUME, '0, '0, '0, 32'h0000_8000 | 32'd500);
        issue(cdc_pkg::C_VOLUME, '0, '0, '0, 32'hffff_ffff);
        issue(cdc_pkg::C_FADE, '0, '0, '0, 32'hffff_ffff);
        issue(cdc_pkg::C_VOLUME, '0, '0, '0, 32'hffff_0000);
    endtask

    task automatic test_random_traffic(input int count, input int gap_pct, input int hold_pct);
        send_pct = gap_pct;
        stall_pct = hold_pct;
        repeat (count) issue_command(random_command());
    endtask

    task automatic test_backpressure();
        send_pct = 0;
        stall_pct = 0;
        hold_request = 300;
        repeat (60) issue_command(random_command());
        repeat (20) issue_command(random_command());
        wait_for_replies();
        repeat (20) issue_command(random_command());
    endtask

    initial begin : run
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_up_state();
        set_disc(19'd524287, 7'd99);
        test_audio_play();
        test_sector_reads();
        test_shrunk_disc();
        test_levels();
        set_disc(19'd524287, 7'd99);
        test_random_traffic(480, 0, 0);
        set_disc(19'($urandom_range(1, 524287)), 7'($urandom_range(1, 99)));
        test_random_traffic(480, 45, 0);
        set_disc(19'd0, 7'd1);
        test_random_traffic(150, 0, 45);
        set_disc(19'($urandom_range(2, 60)), 7'($urandom_range(2, 99)));
        test_random_traffic(330, 0, 45);
        set_disc(19'($urandom_range(1, 524287)), 7'($urandom_range(1, 99)));
        test_random_traffic(480, 11, 11);
        test_backpressure();
        wait_for_replies();
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/cdc_pkg.sv
rtl/core/cdc_cmd.sv
rtl/core/cdc_pipe.sv
rtl/core/cd_drive_command_controller.sv
test/cd_drive_command_controller_test.sv
